/* hdl/mm2h_pkg.sv */
// ----------------------------------------------------------------------------
// mm2h_pkg
// Shared types and constants for the streaming 32-bit MurmurHash2 block.
// ----------------------------------------------------------------------------
package mm2h_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NBYTE_W = 3;

  localparam logic [WORD_W-1:0]  MIX_MUL    = 32'h5bd1_e995;
  localparam logic [WORD_W-1:0]  SEED_RESET = 32'h1337_cafe;
  localparam int unsigned        MIX_SHIFT   = 24;
  localparam int unsigned        FIN_SHIFT_A = 13;
  localparam int unsigned        FIN_SHIFT_B = 15;
  localparam logic [NBYTE_W-1:0] NBYTES_FULL = 3'd4;

  typedef enum logic [2:0] {
    OP_KMUL1,
    OP_KMUL2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN
  } mix_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KMUL1,
    ST_KMUL2,
    ST_HMIX,
    ST_TAIL,
    ST_FIN
  } state_t;

endpackage

/* hdl/mm2h_mix_unit.sv */
// ----------------------------------------------------------------------------
// mm2h_mix_unit
// Shared multiply-by-M unit with operand select and post-multiply xor/shift.
// ----------------------------------------------------------------------------
module mm2h_mix_unit (
  input  mm2h_pkg::mix_op_t       op,
  input  logic [31:0]             h,
  input  logic [31:0]             k,
  input  logic [31:0]             word,
  input  logic [2:0]              nbytes,
  output logic [31:0]             result
);
  import mm2h_pkg::*;

  logic [WORD_W-1:0] tail_bits;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] product;

  always_comb begin
    tail_bits = {24'h0, word[7:0]};
    if (nbytes >= 3'd2) begin
      tail_bits[15:8] = word[15:8];
    end
    if (nbytes >= 3'd3) begin
      tail_bits[23:16] = word[23:16];
    end
  end

  always_comb begin
    case (op)
      OP_KMUL1: operand = word;
      OP_KMUL2: operand = k ^ (k >> MIX_SHIFT);
      OP_HMIX:  operand = h;
      OP_TAIL:  operand = h ^ tail_bits;
      OP_FIN:   operand = h ^ (h >> FIN_SHIFT_A);
      default:  operand = h;
    endcase
  end

  assign product = operand * MIX_MUL;

  always_comb begin
    case (op)
      OP_HMIX: result = product ^ k;
      OP_FIN:  result = product ^ (product >> FIN_SHIFT_B);
      default: result = product;
    endcase
  end

endmodule

/* hdl/murmur2_hash_32.sv */
// ----------------------------------------------------------------------------
// murmur2_hash_32
// Streaming MurmurHash2 (32-bit) over little-endian 32-bit key chunks.
// ----------------------------------------------------------------------------
// One shared 32x32 multiplier by the constant M does all the work under a
// small sequencer. A full 4-byte chunk is its transfer plus three multiplier
// passes (k*M, (k^k>>24)*M, h*M^k); a short chunk is its transfer plus one
// tail pass; a zero-byte chunk is the transfer alone. A chunk marked last adds
// one finalizer pass, which waits there while the output register still holds
// an untaken hash. The input is not ready while a chunk is in progress. The seed
// register may be written at any time the block is idle and applies to the
// next first chunk.
module murmur2_hash_32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        first_chunk,
  input  logic        last_chunk,
  input  logic [31:0] key_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest
);
  import mm2h_pkg::*;

  state_t            state;
  state_t            state_next;
  mix_op_t           op;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] running_hash;
  logic [WORD_W-1:0] k_reg;
  logic [WORD_W-1:0] word_reg;
  logic [NBYTE_W-1:0] nbytes_reg;
  logic              last_reg;
  logic [WORD_W-1:0] mix_result;
  logic [NBYTE_W-1:0] nbytes_in;
  logic              in_xfer;
  logic              out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign nbytes_in = (valid_bytes > NBYTES_FULL) ? NBYTES_FULL : valid_bytes;

  mm2h_mix_unit u_mix (
    .op     (op),
    .h      (running_hash),
    .k      (k_reg),
    .word   (word_reg),
    .nbytes (nbytes_reg),
    .result (mix_result)
  );

  always_comb begin
    state_next = state;
    op         = OP_HMIX;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (nbytes_in == NBYTES_FULL) begin
            state_next = ST_KMUL1;
          end else if (nbytes_in != '0) begin
            state_next = ST_TAIL;
          end else if (last_chunk) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_KMUL1: begin
        op         = OP_KMUL1;
        state_next = ST_KMUL2;
      end
      ST_KMUL2: begin
        op         = OP_KMUL2;
        state_next = ST_HMIX;
      end
      ST_HMIX: begin
        op         = OP_HMIX;
        state_next = last_reg ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        op         = OP_TAIL;
        state_next = last_reg ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        op = OP_FIN;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_wr_en) begin
      seed <= seed_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (in_xfer) begin
      if (first_chunk) begin
        running_hash <= seed ^ key_length;
      end
    end else if (state == ST_HMIX || state == ST_TAIL) begin
      running_hash <= mix_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_reg   <= data_word;
      nbytes_reg <= nbytes_in;
      last_reg   <= last_chunk;
    end
    if (state == ST_KMUL1 || state == ST_KMUL2) begin
      k_reg <= mix_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      digest <= mix_result;
    end
  end

endmodule

/* dv/murmur2_hash_32_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash_32_tb
// Self-checking bench for the streaming MurmurHash2 block. Keys go in as
// little-endian chunks with random gaps; a local mirror of the hash chain
// predicts each finalized hash, and every result is checked in order
// against it. Covers empty keys, short tails, oversized byte counts,
// headless chunks, seed changes, and full output back-pressure.
// ----------------------------------------------------------------------------
module murmur2_hash_32_tb;
  import mm2h_pkg::*;

  localparam int ITEM_TARGET   = 1800;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam int SEGMENT_ITEMS = 120;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        seed_wr_en   = 1'b0;
  logic [31:0] seed_wr_data = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [31:0] data_word    = '0;
  logic [2:0]  valid_bytes  = '0;
  logic        first_chunk  = 1'b0;
  logic        last_chunk   = 1'b0;
  logic [31:0] key_length   = '0;
  logic        out_valid;
  logic        out_ready    = 1'b1;
  logic [31:0] digest;

  logic [31:0] hash_seed  = SEED_RESET;
  logic [31:0] chain_hash = '0;
  logic [31:0] expected_hashes[$];
  int          chunks_sent    = 0;
  int          fail_count     = 0;
  bit          src_gaps_on    = 1'b1;
  bit          sink_stalls_on = 1'b1;
  bit          sink_hold_req  = 1'b0;

  murmur2_hash_32 DUT (
    .clk         (clk),
    .rst         (rst),
    .seed_wr_en  (seed_wr_en),
    .seed_wr_data(seed_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .first_chunk (first_chunk),
    .last_chunk  (last_chunk),
    .key_length  (key_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest      (digest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hash mirror
  function automatic logic [31:0] mix_full_word(logic [31:0] h, logic [31:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL;
    h = h * MIX_MUL;
    return h ^ k;
  endfunction

  function automatic logic [31:0] mix_tail_bytes(logic [31:0] h, logic [31:0] w,
                                                 logic [2:0] nb);
    logic [31:0] mask;
    case (nb)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    h = h ^ (w & mask);
    return h * MIX_MUL;
  endfunction

  function automatic logic [31:0] finalize_hash(logic [31:0] h);
    h = h ^ (h >> FIN_SHIFT_A);
    h = h * MIX_MUL;
    return h ^ (h >> FIN_SHIFT_B);
  endfunction

  function automatic void absorb_chunk(logic [31:0] w, logic [2:0] nb, logic first,
                                       logic last, logic [31:0] len);
    logic [31:0] h;
    logic [2:0]  n;
    n = (nb > NBYTES_FULL) ? NBYTES_FULL : nb;
    h = first ? (hash_seed ^ len) : chain_hash;
    if (n == NBYTES_FULL) h = mix_full_word(h, w);
    else if (n != 3'd0) h = mix_tail_bytes(h, w, n);
    chain_hash = h;
    if (last) expected_hashes.push_back(finalize_hash(h));
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // result sink: random stalls, plus one long hold on request
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_hold_req) begin
        out_ready <= 1'b0;
        stall_left = LONG_HOLD;
        sink_hold_req = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_hash
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $error("digest unexpected: expected none, actual %08h", digest);
        fail_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (digest !== want) begin
          $error("digest mismatch: expected %08h, actual %08h", want, digest);
          fail_count++;
        end
      end
    end
  end

  task automatic send_chunk(input logic [31:0] w, input logic [2:0] nb,
                            input logic first, input logic last,
                            input logic [31:0] len);
    int gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_word   <= w;
    valid_bytes <= nb;
    first_chunk <= first;
    last_chunk  <= last;
    key_length  <= len;
    do @(posedge clk); while (!in_ready);
    absorb_chunk(w, nb, first, last, len);
    chunks_sent++;
  endtask

  task automatic send_key(input int nbytes, input logic [31:0] len);
    int nchunks;
    int remaining;
    logic [2:0] nb;
    nchunks = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
    for (int i = 0; i < nchunks; i++) begin
      remaining = nbytes - 4 * i;
      nb = (remaining >= 4) ? NBYTES_FULL : 3'(remaining);
      if (nb == NBYTES_FULL && $urandom_range(0, 9) == 0) nb = 3'($urandom_range(5, 7));
      send_chunk($urandom, nb, i == 0, i == nchunks - 1, len);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    seed_wr_en   <= 1'b1;
    seed_wr_data <= v;
    @(posedge clk);
    seed_wr_en <= 1'b0;
    hash_seed = v;
    @(posedge clk);
  endtask

  // chain starts at zero when no first chunk was ever seen
  task automatic test_headless_chunk();
    send_chunk(32'hffff_ffff, NBYTES_FULL, 1'b0, 1'b0, 32'hffff_ffff);
    send_chunk(32'h0000_0000, 3'd3, 1'b0, 1'b1, 32'h0);
    wait_drain();
  endtask

  task automatic test_empty_key();
    send_chunk($urandom, 3'd0, 1'b1, 1'b1, 32'h0);
    send_chunk(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'hffff_ffff);
    wait_drain();
  endtask

  task automatic test_word_extremes();
    send_chunk(32'h0000_0000, NBYTES_FULL, 1'b1, 1'b1, 32'd4);
    send_chunk(32'hffff_ffff, NBYTES_FULL, 1'b1, 1'b1, 32'hffff_ffff);
    send_chunk(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b0, 32'd8);
    send_chunk(32'h5a5a_5a5a, 3'd7, 1'b0, 1'b1, 32'd8);
    send_chunk($urandom, 3'd6, 1'b1, 1'b1, 32'd4);
    wait_drain();
  endtask

  task automatic test_short_chunks();
    for (int nb = 1; nb <= 3; nb++)
      send_chunk(32'hffff_ffff, 3'(nb), 1'b1, 1'b1, 32'(nb));
    send_chunk($urandom, NBYTES_FULL, 1'b1, 1'b0, 32'hdead_beef);
    send_chunk(32'hffff_ffff, 3'd2, 1'b0, 1'b0, $urandom);
    send_chunk($urandom, 3'd0, 1'b0, 1'b0, $urandom);
    send_chunk($urandom, 3'd1, 1'b0, 1'b1, $urandom);
    // continue past a finished key without a first chunk
    send_chunk($urandom, NBYTES_FULL, 1'b0, 1'b1, 32'h0);
    wait_drain();
  endtask

  task automatic test_seed_register();
    write_seed(32'h0000_0000);
    send_key(5, 32'd5);
    send_key(0, 32'd0);
    wait_drain();
    write_seed(32'hffff_ffff);
    send_key(7, 32'd7);
    send_key(4, 32'd4);
    wait_drain();
    write_seed(SEED_RESET);
  endtask

  task automatic test_output_backpressure();
    src_gaps_on = 1'b0;
    sink_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_key($urandom_range(0, 4), $urandom);
    wait_drain();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_key(9, 32'd9);
    send_key(3, 32'd3);
    wait_drain();
    send_key(12, 32'd12);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int seg_end;
    int nbytes;
    int pick;
    logic [31:0] len;
    while (chunks_sent < ITEM_TARGET) begin
      seg_end = chunks_sent + SEGMENT_ITEMS;
      src_gaps_on    = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      while (chunks_sent < seg_end) begin
        if ($urandom_range(0, 99) < 88) begin
          nbytes = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 16) : $urandom_range(17, 64);
          len = ($urandom_range(0, 9) == 0) ? $urandom : 32'(nbytes);
          send_key(nbytes, len);
        end else begin
          send_chunk($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom);
        end
      end
      wait_drain();
      pick = $urandom_range(0, 3);
      case (pick)
        0:       write_seed(32'h0000_0000);
        1:       write_seed(32'hffff_ffff);
        default: write_seed($urandom);
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_headless_chunk();
    test_empty_key();
    test_word_extremes();
    test_short_chunks();
    test_seed_register();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    wait_drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
